/* rtl/pnc_pkg.sv */
package pnc_pkg;

  // Fixed result widths
  localparam int ACC_W     = 56;  // normal sums, signed Q.16
  localparam int SUM_W     = 30;  // coordinate sums, signed Q22.8
  localparam int OUT_W     = 24;  // centroid coordinates, signed Q16.8
  localparam int CNT_OUT_W = 7;   // reported vertex count

  // Output tdata: three normals, three centroid coordinates, count, byte padding
  localparam int OUT_USED_W = 3 * ACC_W + 3 * OUT_W + CNT_OUT_W;
  localparam int OUT_DW     = ((OUT_USED_W + 7) / 8) * 8;

  // Axis codes, also the order of the three Newell products
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Tag that travels with a product through the multiplier register
  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
  } mul_tag_t;

endpackage

/* rtl/pnc_mul.sv */
module pnc_mul #(
  parameter int OP_W = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [OP_W-1:0]     a_i,
  input  logic signed [OP_W-1:0]     b_i,
  input  pnc_pkg::mul_tag_t          tag_i,
  output logic signed [2*OP_W-1:0]   prod_o,
  output pnc_pkg::mul_tag_t          tag_o
);

  logic signed [2*OP_W-1:0] prod_q;
  pnc_pkg::mul_tag_t        tag_q;

  // Register the product and its tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;
  assign tag_o  = tag_q;

endmodule

/* rtl/pnc_div.sv */
module pnc_div #(
  parameter int DIV_W = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pnc_pkg::SUM_W-1:0]  dividend_i,
  input  logic [DIV_W-1:0]                  divisor_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic [pnc_pkg::SUM_W-1:0]         quotient_o
);

  localparam int STEP_W = $clog2(pnc_pkg::SUM_W);

  logic                        busy_q;
  logic                        done_q;
  logic                        neg_q;
  logic [pnc_pkg::SUM_W-1:0]   mag_q;
  logic [DIV_W-1:0]            rem_q;
  logic [DIV_W-1:0]            den_q;
  logic [STEP_W-1:0]           step_q;
  logic [DIV_W:0]              rem_sh;
  logic [DIV_W:0]              rem_sub;
  logic                        fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_q, mag_q[pnc_pkg::SUM_W-1]};
    fits    = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
  end

  // Iterate one quotient bit per cycle on the magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      step_q <= '0;
      mag_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= dividend_i[pnc_pkg::SUM_W-1];
        mag_q  <= dividend_i[pnc_pkg::SUM_W-1] ? -dividend_i : dividend_i;
        rem_q  <= '0;
        den_q  <= divisor_i;
        step_q <= '0;
      end else if (busy_q) begin
        rem_q  <= fits ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        mag_q  <= {mag_q[pnc_pkg::SUM_W-2:0], fits};
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(pnc_pkg::SUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Truncate toward zero: negate the magnitude quotient for a negative dividend
  assign quotient_o = neg_q ? -mag_q : mag_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

/* rtl/polygon_normal_and_centroid.sv */
// Per stored vertex after the first: accept, then three passes through the
// shared multiplier. Last vertex: three more passes for the closing edge, then
// three serial divisions (one quotient bit per cycle), then a load of the output
// register once it is empty.
// Reset (rst_ni low, asynchronous) clears all sums, the vertex count and the
// overflow flag, and empties the output register.
module polygon_normal_and_centroid #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_WIDTH  = 24
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // vertex_x, vertex_y, vertex_z from bit 0 up, zero padded
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  input  logic                                      s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // normal_x, normal_y, normal_z, center_x, center_y, center_z, vertex_count,
  // from bit 0 up, zero padded
  output logic [pnc_pkg::OUT_DW-1:0]                m_axis_tdata,
  // too_many
  output logic                                      m_axis_tuser
);

  localparam int CW    = COORD_WIDTH;
  localparam int OP_W  = CW + 1;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int ACC_W = pnc_pkg::ACC_W;
  localparam int SUM_W = pnc_pkg::SUM_W;
  localparam int OUT_W = pnc_pkg::OUT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DIV_WAIT,
    ST_LOAD
  } state_e;

  state_e                   state_q;
  logic [1:0]               axis_q;
  logic                     closing_q;
  logic                     last_q;
  logic signed [CW-1:0]     cur_q   [3];
  logic signed [CW-1:0]     first_q [3];
  logic signed [CW-1:0]     prev_q  [3];
  logic [ACC_W-1:0]         acc_q   [3];
  logic [SUM_W-1:0]         sum_q   [3];
  logic [OUT_W-1:0]         cen_q   [3];
  logic [CNT_W-1:0]         count_q;
  logic                     over_q;

  logic                     out_valid_q;
  logic [ACC_W-1:0]         out_norm_q [3];
  logic [OUT_W-1:0]         out_cen_q  [3];
  logic [pnc_pkg::CNT_OUT_W-1:0] out_count_q;
  logic                     out_over_q;

  logic signed [CW-1:0]     in_vtx [3];
  logic signed [CW-1:0]     b_vtx  [3];
  logic signed [OP_W-1:0]   op_diff;
  logic signed [OP_W-1:0]   op_sum;
  pnc_pkg::mul_tag_t        mul_tag_in;
  pnc_pkg::mul_tag_t        mul_tag;
  logic signed [2*OP_W-1:0] mul_prod;
  logic                     in_acc;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [SUM_W-1:0]         div_quot;

  // Unpack the vertex and pick the far end of the current edge
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_vtx[a] = $signed(s_axis_tdata[a*CW +: CW]);
      b_vtx[a]  = closing_q ? first_q[a] : cur_q[a];
    end
  end

  // Select the difference and sum for the current Newell product
  always_comb begin
    unique case (axis_q)
      pnc_pkg::AXIS_X: begin
        op_diff = OP_W'(prev_q[1]) - OP_W'(b_vtx[1]);
        op_sum  = OP_W'(prev_q[2]) + OP_W'(b_vtx[2]);
      end
      pnc_pkg::AXIS_Y: begin
        op_diff = OP_W'(prev_q[2]) - OP_W'(b_vtx[2]);
        op_sum  = OP_W'(prev_q[0]) + OP_W'(b_vtx[0]);
      end
      pnc_pkg::AXIS_Z: begin
        op_diff = OP_W'(prev_q[0]) - OP_W'(b_vtx[0]);
        op_sum  = OP_W'(prev_q[1]) + OP_W'(b_vtx[1]);
      end
      default: begin
        op_diff = '0;
        op_sum  = '0;
      end
    endcase
    mul_tag_in.valid = (state_q == ST_MUL);
    mul_tag_in.idx   = axis_q;
  end

  pnc_mul #(
    .OP_W (OP_W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .a_i    (op_diff),
    .b_i    (op_sum),
    .tag_i  (mul_tag_in),
    .prod_o (mul_prod),
    .tag_o  (mul_tag)
  );

  assign div_start = (state_q == ST_DIV);

  pnc_div #(
    .DIV_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ($signed(sum_q[axis_q])),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Sequencer, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= pnc_pkg::AXIS_X;
      closing_q   <= 1'b0;
      last_q      <= 1'b0;
      count_q     <= '0;
      over_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        first_q[a] <= '0;
        prev_q[a]  <= '0;
        acc_q[a]   <= '0;
        sum_q[a]   <= '0;
      end
    end else begin
      // Add the registered product into its axis
      if (mul_tag.valid) begin
        acc_q[mul_tag.idx] <= acc_q[mul_tag.idx] + ACC_W'(mul_prod);
      end

      // Drop the output once taken
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            last_q    <= s_axis_tlast;
            axis_q    <= pnc_pkg::AXIS_X;
            closing_q <= 1'b0;
            for (int a = 0; a < 3; a++) begin
              cur_q[a] <= in_vtx[a];
            end
            if (count_q == '0) begin
              // First vertex opens the polygon
              for (int a = 0; a < 3; a++) begin
                first_q[a] <= in_vtx[a];
                prev_q[a]  <= in_vtx[a];
                sum_q[a]   <= SUM_W'(in_vtx[a]);
              end
              count_q <= CNT_W'(1);
              if (s_axis_tlast) begin
                closing_q <= 1'b1;
                state_q   <= ST_MUL;
              end
            end else if (count_q < CNT_W'(MAX_VERTICES)) begin
              state_q <= ST_MUL;
            end else begin
              // Pool full: drop the vertex, still close on a last one
              over_q <= 1'b1;
              if (s_axis_tlast) begin
                closing_q <= 1'b1;
                state_q   <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          if (axis_q == pnc_pkg::AXIS_Z) begin
            axis_q <= pnc_pkg::AXIS_X;
            if (!closing_q) begin
              for (int a = 0; a < 3; a++) begin
                prev_q[a] <= cur_q[a];
                sum_q[a]  <= sum_q[a] + SUM_W'(cur_q[a]);
              end
              count_q <= count_q + 1'b1;
              if (last_q) begin
                closing_q <= 1'b1;
              end else begin
                state_q <= ST_IDLE;
              end
            end else begin
              state_q <= ST_DIV;
            end
          end else begin
            axis_q <= axis_q + 2'd1;
          end
        end
        ST_DIV: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            cen_q[axis_q] <= div_quot[OUT_W-1:0];
            if (axis_q == pnc_pkg::AXIS_Z) begin
              state_q <= ST_LOAD;
            end else begin
              axis_q  <= axis_q + 2'd1;
              state_q <= ST_DIV;
            end
          end
        end
        ST_LOAD: begin
          // Hand over the result and reopen for the next polygon
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            out_count_q <= pnc_pkg::CNT_OUT_W'(count_q);
            out_over_q  <= over_q;
            for (int a = 0; a < 3; a++) begin
              out_norm_q[a] <= acc_q[a];
              out_cen_q[a]  <= cen_q[a];
              first_q[a]    <= '0;
              prev_q[a]     <= '0;
              acc_q[a]      <= '0;
              sum_q[a]      <= '0;
            end
            count_q   <= '0;
            over_q    <= 1'b0;
            closing_q <= 1'b0;
            axis_q    <= pnc_pkg::AXIS_X;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Pack the result item
  always_comb begin
    m_axis_tdata = '0;
    for (int a = 0; a < 3; a++) begin
      m_axis_tdata[a*ACC_W +: ACC_W]           = out_norm_q[a];
      m_axis_tdata[3*ACC_W + a*OUT_W +: OUT_W] = out_cen_q[a];
    end
    m_axis_tdata[3*ACC_W + 3*OUT_W +: pnc_pkg::CNT_OUT_W] = out_count_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_over_q;

  // Input is never taken while a division is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy)
    else $error("vertex accepted during division");

  // Each multiplier issue produces a tagged product in the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> mul_tag.valid)
    else $error("multiplier product lost");

  // Vertex count stays within the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond maximum");

  // Loading a result clears the polygon state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> (count_q == '0 && !over_q))
    else $error("polygon state not cleared on result");

endmodule
